// ===== rtl/nbb_pkg.sv =====
package nbb_pkg;

    // One RGB pixel, red in the low byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pix_t;

    // Request kinds.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Configuration register map.
    localparam int  CFG_IDX_W        = 1;
    localparam int  CFG_DATA_W       = 13;
    localparam int  WIDTH_REG_W      = 11;
    localparam int  HEIGHT_REG_W     = 13;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

    // Stencil size (centre excluded).
    localparam int NBR_COUNT = 8;

endpackage

// ===== rtl/neighbour_blur_3x3.sv =====
// Streaming 3x3 neighbour blur over RGB pixels in raster order.
//
// Input channel (in_valid / in_stall): one request per accepted edge. action
// low carries a pixel on red_in/green_in/blue_in; action high is a flush that
// drains one pending output pixel after the frame's last pixel.
// Output channel (out_valid / out_stall): blurred pixels in raster order, one
// line plus one pixel behind the input; frame_end marks a frame's last pixel.
// Interior pixels get the sum of their eight neighbours, each divided by 8;
// border pixels pass through unchanged.
// Output path: a request that yields a pixel passes the input register,
// then the output register, before it shows on out_valid.
// Throughput: one request per cycle unless in_stall is high; both line
// memories are 1W2R, reads addressed by next-cycle counters: no port conflict.
// Stall: a held output pixel blocks the input register, which then raises
// in_stall; nothing is dropped.
// Reset: counters, pending count and window clear; geometry returns to
// 1024x1024. Line memories are not cleared and need no clearing pass.
// Configuration (cfg_we/cfg_index/cfg_data) should be written while idle.
module neighbour_blur_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_we,
    input  logic [nbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nbb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            action,
    input  logic [7:0]                      red_in,
    input  logic [7:0]                      green_in,
    input  logic [7:0]                      blue_in,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [7:0]                      red_out,
    output logic [7:0]                      green_out,
    output logic [7:0]                      blue_out,
    output logic                            frame_end
);
    import nbb_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);      // column index
    localparam int RB = $clog2(MAX_HEIGHT);     // row index
    localparam int PW = $clog2(MAX_WIDTH + 2);  // width / pending count
    localparam int HW = $clog2(MAX_HEIGHT + 1); // height

    // ---------------- configuration ----------------
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [PW-1:0]           w_eff;
    logic [HW-1:0]           h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero counts as one, oversize clamps to the maximum.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = PW'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = PW'(MAX_WIDTH);
        else
            w_eff = PW'(width_reg);

        if (height_reg == '0)
            h_eff = HW'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(height_reg);
    end

    // ---------------- input register ----------------
    logic in_vld_reg;
    logic act_reg;
    pix_t pix_in_reg;
    logic out_vld_reg;
    logic fire;
    logic accept;

    // Work stage advances when the output register is empty or draining.
    assign fire     = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (accept)
            in_vld_reg <= 1'b1;
        else if (fire)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg          <= action;
            pix_in_reg.red   <= red_in;
            pix_in_reg.green <= green_in;
            pix_in_reg.blue  <= blue_in;
        end
    end

    // ---------------- stream state ----------------
    logic [CB-1:0] in_col_reg,  in_col_next;
    logic [RB-1:0] in_row_reg,  in_row_next;
    logic [CB-1:0] out_col_reg, out_col_next;
    logic [RB-1:0] out_row_reg, out_row_next;
    logic [PW-1:0] pending_reg, pending_next;
    pix_t          win_reg [6];

    logic is_flush;
    logic full;
    logic interior;
    logic produce;
    logic last_pix;
    logic pix_step;
    logic out_step;
    pix_t up_a, up_b, mid_a, mid_b;
    pix_t blur_pix;
    pix_t res_pix;
    pix_t nbr [NBR_COUNT];

    assign is_flush = (act_reg == ACT_FLUSH);
    // A full line plus one pixel is buffered: the oldest one is owed now.
    assign full     = pending_reg >= (w_eff + PW'(1));
    assign interior = (out_row_reg != '0) && ((HW'(out_row_reg) + HW'(1)) < h_eff) &&
                      (out_col_reg != '0) && ((PW'(out_col_reg) + PW'(1)) < w_eff);
    assign last_pix = ((PW'(out_col_reg) + PW'(1)) >= w_eff) &&
                      ((HW'(out_row_reg) + HW'(1)) >= h_eff);
    assign produce  = is_flush ? (pending_reg != '0) : full;
    assign pix_step = fire && !is_flush;
    assign out_step = fire && produce;

    // Stencil around the output pixel; window holds the two prior columns.
    assign nbr[0] = win_reg[0];
    assign nbr[1] = win_reg[3];
    assign nbr[2] = up_a;
    assign nbr[3] = win_reg[1];
    assign nbr[4] = mid_a;
    assign nbr[5] = win_reg[2];
    assign nbr[6] = win_reg[5];
    assign nbr[7] = pix_in_reg;

    nbb_blur u_blur (
        .nbr (nbr),
        .avg (blur_pix)
    );

    // Flushes never blur, even for an interior position.
    always_comb
    begin
        if (is_flush)
            res_pix = full ? up_b : mid_b;
        else
            res_pix = interior ? blur_pix : up_b;
    end

    // Raster counters wrap at the current geometry.
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pending_next = pending_reg;

        if (pix_step)
        begin
            if ((PW'(in_col_reg) + PW'(1)) >= w_eff)
            begin
                in_col_next = '0;
                in_row_next = ((HW'(in_row_reg) + HW'(1)) >= h_eff) ? '0
                                                                    : in_row_reg + RB'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CB'(1);
            end
        end

        if (out_step)
        begin
            if ((PW'(out_col_reg) + PW'(1)) >= w_eff)
            begin
                out_col_next = '0;
                out_row_next = ((HW'(out_row_reg) + HW'(1)) >= h_eff) ? '0
                                                                      : out_row_reg + RB'(1);
            end
            else
            begin
                out_col_next = out_col_reg + CB'(1);
            end
        end

        // pixel: +1 unless one leaves; flush: -1 when one leaves
        if (pix_step && !full)
            pending_next = pending_reg + PW'(1);
        else if (fire && is_flush && produce)
            pending_next = pending_reg - PW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pending_reg <= '0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pending_reg <= pending_next;
            if (pix_step)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= up_a;
                win_reg[4] <= mid_a;
                win_reg[5] <= pix_in_reg;
            end
        end
    end

    // ---------------- line memories ----------------
    // Reads are addressed by next-cycle counters so data lines up with the
    // request sitting in the input register; port b serves the output side.
    nbb_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CB)
    ) u_upper (
        .clk     (clk),
        .we      (pix_step),
        .waddr   (in_col_reg),
        .wdata   (mid_a),
        .raddr_a (in_col_next),
        .rdata_a (up_a),
        .raddr_b (out_col_next),
        .rdata_b (up_b)
    );

    nbb_line_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CB)
    ) u_middle (
        .clk     (clk),
        .we      (pix_step),
        .waddr   (in_col_reg),
        .wdata   (pix_in_reg),
        .raddr_a (in_col_next),
        .rdata_a (mid_a),
        .raddr_b (out_col_next),
        .rdata_b (mid_b)
    );

    // ---------------- output register ----------------
    pix_t out_pix_reg;
    logic frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_step)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_step)
        begin
            out_pix_reg   <= res_pix;
            frame_end_reg <= last_pix;
        end
    end

    assign out_valid = out_vld_reg;
    assign red_out   = out_pix_reg.red;
    assign green_out = out_pix_reg.green;
    assign blue_out  = out_pix_reg.blue;
    assign frame_end = frame_end_reg;

    // ---------------- assertions ----------------
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PW'(MAX_WIDTH + 1))
        else $error("pending count above one line plus one pixel");

    a_pending_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_step && !full) |=> (pending_reg == $past(pending_reg) + PW'(1)))
        else $error("pixel without output did not grow pending count");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(fire))
        else $error("output became valid without a processed request");

endmodule

// ===== rtl/nbb_line_ram.sv =====
module nbb_line_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  nbb_pkg::pix_t   wdata,
    input  logic [AW-1:0]   raddr_a,
    output nbb_pkg::pix_t   rdata_a,
    input  logic [AW-1:0]   raddr_b,
    output nbb_pkg::pix_t   rdata_b
);
    import nbb_pkg::*;

    pix_t mem_reg [DEPTH];
    pix_t rd_a_reg;
    pix_t rd_b_reg;

    // 1W2R, registered reads, write-first on address match.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= (we && waddr == raddr_a) ? wdata : mem_reg[raddr_a];
        rd_b_reg <= (we && waddr == raddr_b) ? wdata : mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

// ===== rtl/nbb_blur.sv =====
module nbb_blur (
    input  nbb_pkg::pix_t nbr [nbb_pkg::NBR_COUNT],
    output nbb_pkg::pix_t avg
);
    import nbb_pkg::*;

    logic [7:0] sum_r;
    logic [7:0] sum_g;
    logic [7:0] sum_b;

    // Each term is pre-shifted, so the total stays below 249.
    always_comb
    begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < NBR_COUNT; k++)
        begin
            sum_r = sum_r + (nbr[k].red   >> 3);
            sum_g = sum_g + (nbr[k].green >> 3);
            sum_b = sum_b + (nbr[k].blue  >> 3);
        end
    end

    assign avg.red   = sum_r;
    assign avg.green = sum_g;
    assign avg.blue  = sum_b;

endmodule

// ===== bench/neighbour_blur_3x3_tb.sv =====
module neighbour_blur_3x3_tb;

    import nbb_pkg::*;

    localparam int MAX_W           = 1024;
    localparam int MAX_H           = 4096;
    localparam int PRIME_W         = 16;    // columns written before anything else runs
    localparam int PRIME_ROWS      = 4;
    localparam int HOLD_CYCLES     = 150;   // long output hold-off for the pressure test
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no handshake on either side
    localparam int SETTLE_CYCLES   = 4;     // input reg + output reg, with margin
    localparam int RANDOM_REQUESTS = 1100;

    // expected output pixel
    typedef struct packed {
        pix_t px;
        logic frame_end;
    } blurred_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  action    = ACT_PIXEL;
    logic [7:0]            red_in    = '0;
    logic [7:0]            green_in  = '0;
    logic [7:0]            blue_in   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    logic [7:0]            red_out;
    logic [7:0]            green_out;
    logic [7:0]            blue_out;
    logic                  frame_end;

    neighbour_blur_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Blur predictor state: geometry registers, both line memories, the
    // 2-column window, raster counters on each side and the owed count.
    // ------------------------------------------------------------------
    logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RESET;
    logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RESET;
    pix_t        top_row [MAX_W];
    pix_t        mid_row [MAX_W];
    pix_t        win [6];
    int unsigned col_in      = 0;
    int unsigned row_in      = 0;
    int unsigned col_out     = 0;
    int unsigned row_out     = 0;
    int unsigned owed_pixels = 0;

    blurred_t    blurred_due[$];

    // bookkeeping
    int unsigned fail_count      = 0;
    int unsigned requests_sent   = 0;
    int unsigned useful_requests = 0;   // pixels and flushes that drain something
    int unsigned pixels_checked  = 0;
    int unsigned regs_written    = 0;
    int unsigned quiet_cycles    = 0;

    // idling controls shared by the test tasks and the receiver process
    bit          gap_mode   = 1'b1;
    bit          stall_mode = 1'b1;
    bit          hold_ask   = 1'b0;
    int unsigned hold_left  = 0;
    int unsigned stall_left = 0;

    initial
    begin
        for (int i = 0; i < MAX_W; i++)
        begin
            top_row[i] = '0;
            mid_row[i] = '0;
        end
        for (int i = 0; i < 6; i++)
            win[i] = '0;
    end

    // register value 0 means 1, oversize values clamp to the build limit
    function automatic int unsigned active_width();
        if (width_reg == 0)
            return 1;
        return (width_reg > MAX_W) ? MAX_W : width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg == 0)
            return 1;
        return (height_reg > MAX_H) ? MAX_H : height_reg;
    endfunction

    // per channel: sum of each neighbour / 8, floor; max 8*31 = 248
    function automatic pix_t blur_eight(input logic [8*24-1:0] nb);
        pix_t        p;
        pix_t        res;
        logic [10:0] rs;
        logic [10:0] gs;
        logic [10:0] bs;
        int          k;
        rs = '0;
        gs = '0;
        bs = '0;
        for (k = 0; k < 8; k++)
        begin
            p  = nb[k*24 +: 24];
            rs = rs + 11'(p.red >> 3);
            gs = gs + 11'(p.green >> 3);
            bs = bs + 11'(p.blue >> 3);
        end
        res.red   = rs[7:0];
        res.green = gs[7:0];
        res.blue  = bs[7:0];
        return res;
    endfunction

    // raster advance; wraps at the current geometry, also from outside it
    task automatic step_position(inout int unsigned c, inout int unsigned r,
                                 input int unsigned w, input int unsigned h);
        if (c + 1 >= w)
        begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            c = c + 1;
    endtask

    task automatic queue_blurred(input pix_t px, input int unsigned w, input int unsigned h);
        blurred_t item;
        item.px        = px;
        item.frame_end = (col_out + 1 >= w) && (row_out + 1 >= h);
        blurred_due.push_back(item);
        step_position(col_out, row_out, w, h);
        owed_pixels--;
    endtask

    // Called at the edge where a request is accepted.
    task automatic predict_blur(input logic act, input pix_t px);
        int unsigned w;
        int unsigned h;
        pix_t        up;
        pix_t        mid;
        pix_t        res;
        logic        interior;
        w = active_width();
        h = active_height();
        if (act == ACT_FLUSH)
        begin
            // flush with nothing owed is simply dropped
            if (owed_pixels != 0)
            begin
                // the oldest owed pixel is still in the top line while a full
                // line plus one is owed, otherwise in the middle line
                res = (owed_pixels >= w + 1) ? top_row[col_out] : mid_row[col_out];
                queue_blurred(res, w, h);
                useful_requests++;
            end
        end
        else
        begin
            up  = top_row[col_in];
            mid = mid_row[col_in];
            if (owed_pixels >= w + 1)
            begin
                interior = (row_out >= 1) && (row_out + 1 < h) &&
                           (col_out >= 1) && (col_out + 1 < w);
                if (interior)
                    res = blur_eight({win[0], win[3], up, win[1], mid,
                                      win[2], win[5], px});
                else
                    res = top_row[col_out];
                queue_blurred(res, w, h);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up;
            win[4] = mid;
            win[5] = px;
            top_row[col_in] = mid;
            mid_row[col_in] = px;
            step_position(col_in, row_in, w, h);
            owed_pixels++;
            useful_requests++;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly short idle runs, now and then a long one
    function automatic int unsigned pick_idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // channel values lean toward the extremes and the divide-by-8 boundary
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h07;
            3:       return 8'h08;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pix_t random_pixel();
        pix_t p;
        p.red   = random_channel();
        p.green = random_channel();
        p.blue  = random_channel();
        return p;
    endfunction

    // Drives one request at a falling edge and returns at the accepting
    // rising edge. valid stays high for a following back-to-back request.
    task automatic send_request(input logic act, input pix_t px);
        int unsigned gap;
        gap = 0;
        if (gap_mode && $urandom_range(0, 99) < 30)
            gap = pick_idle_len();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        red_in   <= px.red;
        green_in <= px.green;
        blue_in  <= px.blue;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        requests_sent++;
        predict_blur(act, px);
    endtask

    task automatic flush_owed();
        int unsigned n;
        n = owed_pixels;
        repeat (n) send_request(ACT_FLUSH, random_pixel());
    endtask

    // Drop valid, wait for every expected pixel, then let the pipeline settle
    // so a request with no output has fully retired.
    task automatic drain_and_settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (blurred_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called while idle
    task automatic write_geometry(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_IMAGE_WIDTH)
            width_reg = val[WIDTH_REG_W-1:0];
        else
            height_reg = val[HEIGHT_REG_W-1:0];
        regs_written++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // 16 wide, 8 tall: four rows put a written value in the first 16 entries
    // of both line memories. Every later geometry stays within those columns
    // (the clamped width only touches the first few, with nothing owed), so
    // no unwritten entry is read. Rows 1 and 2 check interior blur; the drain
    // then flushes mid-frame.
    task automatic test_line_prime();
        write_geometry(REG_IMAGE_WIDTH, 13'(PRIME_W));
        write_geometry(REG_IMAGE_HEIGHT, 13'd8);
        repeat (PRIME_ROWS * PRIME_W) send_request(ACT_PIXEL, random_pixel());
        flush_owed();
    endtask

    // Input sits on row 4; shrinking to 3x3 leaves that row outside the
    // frame, so it finishes as an edge row and the counters wrap. The next
    // frame is all ones, so its center blurs to 248.
    task automatic test_geometry_change_mid_frame();
        pix_t white;
        white = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
        drain_and_settle();
        write_geometry(REG_IMAGE_WIDTH, 13'd3);
        write_geometry(REG_IMAGE_HEIGHT, 13'd3);
        repeat (3) send_request(ACT_PIXEL, random_pixel());
        repeat (9) send_request(ACT_PIXEL, white);
    endtask

    // No flush between frames: the new frame pushes out the old tail.
    // Then drain, plus one flush with nothing owed.
    task automatic test_back_to_back_frames();
        pix_t p;
        for (int i = 0; i < 9; i++)
        begin
            p.red   = (i % 2 != 0) ? 8'hFF : 8'h00;
            p.green = (i % 3 == 0) ? 8'h07 : 8'hF8;
            p.blue  = (i % 4 < 2)  ? 8'h08 : 8'hFF;
            send_request(ACT_PIXEL, p);
        end
        flush_owed();
        send_request(ACT_FLUSH, random_pixel());
    endtask

    // Flushes in the middle of a frame: first one drains from the top line,
    // later ones from the middle line; all pass through without blur.
    task automatic test_flush_mid_frame();
        repeat (5) send_request(ACT_PIXEL, random_pixel());
        repeat (3) send_request(ACT_FLUSH, random_pixel());
        repeat (2) send_request(ACT_PIXEL, random_pixel());
        flush_owed();
    endtask

    // Zero means one; bits above the register width are dropped; the widest
    // values clamp to the build limits. Both phases start with nothing owed
    // and the input and output counters lined up.
    task automatic test_register_extremes();
        drain_and_settle();
        write_geometry(REG_IMAGE_WIDTH, 13'h1800);
        write_geometry(REG_IMAGE_HEIGHT, 13'h0000);
        repeat (3) send_request(ACT_PIXEL, random_pixel());
        flush_owed();
        drain_and_settle();
        write_geometry(REG_IMAGE_WIDTH, 13'h1FFF);
        write_geometry(REG_IMAGE_HEIGHT, 13'h1FFF);
        repeat (3) send_request(ACT_PIXEL, random_pixel());
        flush_owed();
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back-to-back pixels; the block has to fill and raise in_stall.
    task automatic test_output_hold();
        drain_and_settle();
        write_geometry(REG_IMAGE_WIDTH, 13'd4);
        write_geometry(REG_IMAGE_HEIGHT, 13'd3);
        gap_mode = 1'b0;
        hold_ask = 1'b1;
        repeat (24) send_request(ACT_PIXEL, random_pixel());
        flush_owed();
        gap_mode = 1'b1;
    endtask

    // Random phases: mostly whole frames at small geometries (the first one
    // finishes whatever frame is open), some noise with many flushes, and
    // once in a while a raw register value with bits above the field set.
    task automatic test_random_frames();
        int unsigned target;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        target = useful_requests + RANDOM_REQUESTS;
        while (useful_requests < target)
        begin
            drain_and_settle();
            gap_mode   = ($urandom_range(0, 3) != 0);
            stall_mode = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0)
            begin
                // width stays within the primed columns once masked
                write_geometry(REG_IMAGE_WIDTH,
                               13'($urandom_range(0, 3) * 2048 + $urandom_range(0, PRIME_W)));
                write_geometry(REG_IMAGE_HEIGHT, 13'($urandom_range(0, 8191)));
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    write_geometry(REG_IMAGE_WIDTH, 13'($urandom_range(1, 12)));
                if ($urandom_range(0, 3) != 0)
                    write_geometry(REG_IMAGE_HEIGHT, 13'($urandom_range(1, 8)));
            end
            w = active_width();
            h = active_height();
            if ($urandom_range(0, 9) < 7)
            begin
                if (row_in < h && col_in < w)
                    n = (h - row_in - 1) * w + (w - col_in);
                else
                    n = w * h;
                n = n + w * h * $urandom_range(0, 2);
                if (n > 240)
                    n = $urandom_range(20, 240);
                repeat (n)
                begin
                    if ($urandom_range(0, 29) == 0)
                        send_request(ACT_FLUSH, random_pixel());
                    send_request(ACT_PIXEL, random_pixel());
                end
                if ($urandom_range(0, 1) != 0)
                    flush_owed();
                if ($urandom_range(0, 4) == 0)
                    send_request(ACT_FLUSH, random_pixel());
            end
            else
            begin
                n = $urandom_range(5, 40);
                repeat (n)
                    send_request(($urandom_range(0, 2) == 0) ? ACT_FLUSH : ACT_PIXEL,
                                 random_pixel());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: long hold on request, otherwise random stall runs
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_ask)
        begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stall_mode && $urandom_range(0, 99) < 20)
        begin
            stall_left = pick_idle_len() - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // each accepted output pixel against the oldest expectation
    always @(posedge clk)
    begin : check_output
        blurred_t want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (blurred_due.size() == 0)
            begin
                $error("output pixel with nothing expected: r=%0d g=%0d b=%0d",
                       red_out, green_out, blue_out);
                fail_count++;
            end
            else
            begin
                want = blurred_due.pop_front();
                check_field("red_out", want.px.red, red_out);
                check_field("green_out", want.px.green, green_out);
                check_field("blue_out", want.px.blue, blue_out);
                check_field("frame_end", want.frame_end, frame_end);
                pixels_checked++;
            end
        end
    end

    // hang guard: no handshake on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_line_prime();
        test_geometry_change_mid_frame();
        test_back_to_back_frames();
        test_flush_mid_frame();
        test_register_extremes();
        test_output_hold();
        test_random_frames();

        drain_and_settle();
        if (blurred_due.size() != 0)
        begin
            $error("%0d expected pixels never arrived", blurred_due.size());
            fail_count++;
        end

        $display("summary: %0d requests, %0d output pixels checked, %0d register writes",
                 requests_sent, pixels_checked, regs_written);
        $display("summary: line priming, masked/clamped geometry, mid-frame flush %s",
                 "and resize, back-to-back frames, long output hold");
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
